// ===== rtl/ake_pkg.sv =====
// AES key expansion: shared types, constants, S-box table and GF(2^8) helpers.
// No dependencies; imported by the channel interfaces and all rtl modules.
`timescale 1ns / 1ps
`default_nettype none

package ake_pkg;

  localparam int unsigned KeyWordW = 32;
  localparam int unsigned IndexW   = 6;
  localparam int unsigned WinDepth = 8;
  localparam int unsigned WinIdxW  = $clog2(WinDepth);
  localparam int unsigned CountW   = 4;
  localparam int unsigned StepW    = 2;

  localparam logic [1:0] KeySize128 = 2'd0;
  localparam logic [1:0] KeySize192 = 2'd1;

  localparam logic [7:0] RconStart = 8'h01;

  // microprogram step addresses
  localparam logic [StepW-1:0] StepLoad   = 2'd0;
  localparam logic [StepW-1:0] StepStart  = 2'd1;
  localparam logic [StepW-1:0] StepExpand = 2'd2;

  typedef enum logic [1:0] {
    CondAlways  = 2'd0,
    CondKeyDone = 2'd1,
    CondLast    = 2'd2
  } cond_e;

  typedef struct packed {
    logic             take_key;
    logic             init;
    logic             emit;
    cond_e            cond;
    logic [StepW-1:0] target;
  } uword_t;

  // datapath controls issued by the sequencer
  typedef struct packed {
    logic               load;
    logic [WinIdxW-1:0] wr_idx;
    logic               init;
    logic               advance;
  } ctl_t;

  typedef struct packed {
    logic out_free;
    logic last_word;
  } stat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // the control store
  function automatic uword_t ucode(logic [StepW-1:0] step);
    uword_t uw;
    uw = '{take_key: 1'b0, init: 1'b0, emit: 1'b0, cond: CondAlways, target: StepLoad};
    unique case (step)
      StepLoad:   uw = '{take_key: 1'b1, init: 1'b0, emit: 1'b0,
                         cond: CondKeyDone, target: StepStart};
      StepStart:  uw = '{take_key: 1'b0, init: 1'b1, emit: 1'b0,
                         cond: CondAlways, target: StepExpand};
      StepExpand: uw = '{take_key: 1'b0, init: 1'b0, emit: 1'b1,
                         cond: CondLast, target: StepLoad};
      default:    uw = '{take_key: 1'b0, init: 1'b0, emit: 1'b0,
                         cond: CondAlways, target: StepLoad};
    endcase
    return uw;
  endfunction

  // size codes two and three both act as 256 bits
  function automatic logic [CountW-1:0] words_per_key(logic [1:0] ks);
    logic [CountW-1:0] nk;
    unique case (ks)
      KeySize128: nk = 4'd4;
      KeySize192: nk = 4'd6;
      default:    nk = 4'd8;
    endcase
    return nk;
  endfunction

  function automatic logic [IndexW-1:0] last_index(logic [1:0] ks);
    logic [IndexW-1:0] li;
    unique case (ks)
      KeySize128: li = 6'd43;
      KeySize192: li = 6'd51;
      default:    li = 6'd59;
    endcase
    return li;
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [KeyWordW-1:0] sbox_word(logic [KeyWordW-1:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [KeyWordW-1:0] inv_mix_column(logic [KeyWordW-1:0] w);
    logic [7:0] a  [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] m2, m4, m8;
    for (int k = 0; k < 4; k++) begin
      a[k]  = w[31-8*k -: 8];
      m2    = xtime(a[k]);
      m4    = xtime(m2);
      m8    = xtime(m4);
      m9[k] = m8 ^ a[k];
      mb[k] = m8 ^ m2 ^ a[k];
      md[k] = m8 ^ m4 ^ a[k];
      me[k] = m8 ^ m4 ^ m2;
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
            m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3],
            mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ake_if.sv =====
// Valid/ready channels of the key expansion: key word input, round-key word output.
// Depends on ake_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ake_key_if import ake_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KeyWordW-1:0] key_word;

  modport source (output valid, output key_word, input ready);
  modport sink (input valid, input key_word, output ready);
endinterface

interface ake_word_if import ake_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IndexW-1:0]   word_index;
  logic [KeyWordW-1:0] round_word;
  logic [KeyWordW-1:0] inverse_round_word;
  logic                last;

  modport source (output valid, output word_index, output round_word,
                  output inverse_round_word, output last, input ready);
  modport sink (input valid, input word_index, input round_word,
                input inverse_round_word, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/ake_datapath.sv =====
// Key window, round-key generator (RotWord/SubWord/Rcon), InvMixColumns and output register.
// Depends on ake_pkg and ake_if; driven by the sequencer in aes_key_expansion.
`timescale 1ns / 1ps
`default_nettype none

module ake_datapath import ake_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ctl_t                ctl_i,
  input  wire logic [1:0]          key_size_i,
  input  wire logic [KeyWordW-1:0] key_word_i,
  output      stat_t               stat_o,
  ake_word_if.source               res_o
);

  logic [KeyWordW-1:0] win_q [WinDepth];
  logic [KeyWordW-1:0] win_d [WinDepth];
  logic [IndexW-1:0]   idx_q, idx_d;
  logic [WinIdxW-1:0]  phase_q, phase_d;
  logic [7:0]          rcon_q, rcon_d;

  logic                out_valid_q, out_valid_d;
  logic [IndexW-1:0]   out_idx_q;
  logic [KeyWordW-1:0] out_word_q, out_inv_q;
  logic                out_last_q;

  logic [CountW-1:0]   nk;
  logic [IndexW-1:0]   last_idx;
  logic [KeyWordW-1:0] tap, sub_in, sub_out, tmp, new_word;
  logic                rcon_step, mid_round;

  assign nk       = words_per_key(key_size_i);
  assign last_idx = last_index(key_size_i);

  // window slot k holds w[i+k]; the oldest sits in slot 0
  always_comb begin
    unique case (key_size_i)
      KeySize128: tap = win_q[3];
      KeySize192: tap = win_q[5];
      default:    tap = win_q[7];
    endcase
  end

  assign rcon_step = (phase_q == '0);
  assign sub_in    = rcon_step ? {tap[23:0], tap[31:24]} : tap;
  assign sub_out   = sbox_word(sub_in);

  always_comb begin
    tmp    = tap;
    rcon_d = rcon_q;
    if (rcon_step) begin
      tmp    = sub_out ^ {rcon_q, 24'h0};
      rcon_d = xtime(rcon_q);
    end else if (nk == 4'd8 && phase_q == 3'd4) begin
      tmp = sub_out;
    end
    if (ctl_i.init) begin
      rcon_d = RconStart;
    end else if (!ctl_i.advance) begin
      rcon_d = rcon_q;
    end
  end

  assign new_word = win_q[0] ^ tmp;

  always_comb begin
    for (int j = 0; j < WinDepth - 1; j++) begin
      win_d[j] = (CountW'(j + 1) == nk) ? new_word : win_q[j+1];
    end
    win_d[WinDepth-1] = (CountW'(WinDepth) == nk) ? new_word : win_q[WinDepth-1];
  end

  always_comb begin
    idx_d   = idx_q;
    phase_d = phase_q;
    if (ctl_i.init) begin
      idx_d   = '0;
      phase_d = '0;
    end else if (ctl_i.advance) begin
      idx_d   = idx_q + 6'd1;
      phase_d = ({1'b0, phase_q} == nk - 4'd1) ? '0 : phase_q + 3'd1;
    end
  end

  // rounds 1 to Nr-1 get InvMixColumns
  assign mid_round = (idx_q >= 6'd4) && (idx_q < last_idx - 6'd3);

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_i.advance) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      win_q[ctl_i.wr_idx] <= key_word_i;
    end else if (ctl_i.advance) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      out_idx_q  <= idx_q;
      out_word_q <= win_q[0];
      out_inv_q  <= mid_round ? inv_mix_column(win_q[0]) : win_q[0];
      out_last_q <= (idx_q == last_idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      phase_q     <= '0;
      rcon_q      <= RconStart;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      phase_q     <= phase_d;
      rcon_q      <= rcon_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign stat_o.out_free  = !out_valid_q || res_o.ready;
  assign stat_o.last_word = (idx_q == last_idx);

  assign res_o.valid              = out_valid_q;
  assign res_o.word_index         = out_idx_q;
  assign res_o.round_word         = out_word_q;
  assign res_o.inverse_round_word = out_inv_q;
  assign res_o.last               = out_last_q;

  property p_init_clears_rcon;
    @(posedge clk_i) disable iff (!rst_ni) ctl_i.init |=> rcon_q == RconStart && idx_q == '0;
  endproperty
  a_init_clears_rcon: assert property (p_init_clears_rcon)
    else $error("schedule start did not reset Rcon and word index");

  property p_no_load_while_stepping;
    @(posedge clk_i) disable iff (!rst_ni) !(ctl_i.load && ctl_i.advance);
  endproperty
  a_no_load_while_stepping: assert property (p_no_load_while_stepping)
    else $error("key load and window shift in the same cycle");

  property p_index_follows;
    @(posedge clk_i) disable iff (!rst_ni)
      ctl_i.advance && !ctl_i.init |=> out_idx_q == $past(idx_q) && idx_q == $past(idx_q) + 6'd1;
  endproperty
  a_index_follows: assert property (p_index_follows)
    else $error("word index did not step with the window");

endmodule

`default_nettype wire

// ===== rtl/aes_key_expansion.sv =====
// After the request carrying the last key word, the setup step and then the expand step run, and the
// output register gives the first round-key word; one word follows per cycle while the sink takes them.
// Nk key requests (4/6/8) are taken one per cycle while the source offers them, then 1 setup
// step and 44/52/60 generate steps follow, set by the single window-shift/S-box round-key unit.
// Reset: asynchronous, active low; key_size returns to 128 bits, load count to zero.
// Top level: APB config register and microcoded sequencer; depends on ake_pkg, ake_if, ake_datapath.
`timescale 1ns / 1ps
`default_nettype none

module aes_key_expansion import ake_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  ake_key_if.sink          key_i,
  ake_word_if.source       res_o
);

  logic [1:0]        key_size_q;
  logic [StepW-1:0]  pc_q, pc_d;
  logic [CountW-1:0] load_count_q, load_count_d;
  logic [CountW:0]   count_next;
  uword_t            uw;
  ctl_t              ctl;
  stat_t             stat;
  logic              accept, key_done, advance, cond_true, cfg_wr;

  // configuration register, one word at address 0
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {30'h0, key_size_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_size_q <= KeySize128;
    end else if (cfg_wr) begin
      key_size_q <= pwdata[1:0];
    end
  end

  // sequencer
  assign uw          = ucode(pc_q);
  assign key_i.ready = uw.take_key;
  assign accept      = key_i.valid && key_i.ready;
  assign count_next  = {1'b0, load_count_q} + 5'd1;
  assign key_done    = count_next >= {1'b0, words_per_key(key_size_q)};
  assign advance     = uw.emit && stat.out_free;

  always_comb begin
    unique case (uw.cond)
      CondAlways:  cond_true = 1'b1;
      CondKeyDone: cond_true = accept && key_done;
      CondLast:    cond_true = advance && stat.last_word;
      default:     cond_true = 1'b0;
    endcase
  end

  assign pc_d = cond_true ? uw.target : pc_q;

  always_comb begin
    load_count_d = load_count_q;
    if (accept) begin
      load_count_d = key_done ? '0 : count_next[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= StepLoad;
      load_count_q <= '0;
    end else begin
      pc_q         <= pc_d;
      load_count_q <= load_count_d;
    end
  end

  assign ctl.load    = accept;
  assign ctl.wr_idx  = load_count_q[WinIdxW-1:0];
  assign ctl.init    = uw.init;
  assign ctl.advance = advance;

  ake_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .key_size_i (key_size_q),
    .key_word_i (key_i.key_word),
    .stat_o     (stat),
    .res_o      (res_o)
  );

  property p_accept_only_loading;
    @(posedge clk_i) disable iff (!rst_ni) accept |-> pc_q == StepLoad;
  endproperty
  a_accept_only_loading: assert property (p_accept_only_loading)
    else $error("key word taken outside the load step");

  property p_start_to_expand;
    @(posedge clk_i) disable iff (!rst_ni) pc_q == StepStart |=> pc_q == StepExpand;
  endproperty
  a_start_to_expand: assert property (p_start_to_expand)
    else $error("setup step did not fall through to expansion");

  property p_count_clear_expanding;
    @(posedge clk_i) disable iff (!rst_ni) pc_q == StepExpand |-> load_count_q == '0;
  endproperty
  a_count_clear_expanding: assert property (p_count_clear_expanding)
    else $error("load count not cleared during expansion");

  property p_last_index;
    @(posedge clk_i) disable iff (!rst_ni)
      res_o.valid && res_o.last |-> res_o.word_index == last_index(key_size_q);
  endproperty
  a_last_index: assert property (p_last_index)
    else $error("last flag on a word other than the final one");

endmodule

`default_nettype wire
